// ===== sv/i2cm_pkg.sv =====
// Shared types and constants for the I2C master register access block.
package i2cm_pkg;

    typedef enum logic [4:0] {
        S_IDLE = 5'd0,
        S_STA  = 5'd1,
        S_STB  = 5'd2,
        S_STC  = 5'd3,
        S_TXS  = 5'd4,
        S_TXH  = 5'd5,
        S_TXL  = 5'd6,
        S_TAS  = 5'd7,
        S_TAH  = 5'd8,
        S_TAL  = 5'd9,
        S_RXH  = 5'd10,
        S_RXL  = 5'd11,
        S_RAS  = 5'd12,
        S_RAH  = 5'd13,
        S_RAL  = 5'd14,
        S_SPA  = 5'd15,
        S_SPB  = 5'd16,
        S_SPC  = 5'd17
    } t_state;

    localparam logic [1:0]  ACT_TICK  = 2'd0;
    localparam logic [1:0]  ACT_WRITE = 2'd1;
    localparam logic [1:0]  ACT_READ  = 2'd2;

    localparam logic [1:0]  STAGE_DEV  = 2'd0;
    localparam logic [1:0]  STAGE_REG  = 2'd1;
    localparam logic [1:0]  STAGE_DATA = 2'd2;

    localparam logic [1:0]  STAT_OK = 2'd0;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;
    localparam logic        CFG_IDX_PHASE     = 1'b0;

    localparam logic [7:0]  RD_BIT   = 8'h01;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    localparam int IN_W  = 40;
    localparam int OUT_W = 16;

endpackage

// ===== sv/i2c_master_register_access.sv =====
// I2C master register access: bus sequencer advanced by one input beat per tick.
// The result beat of an input beat is registered and presented in the cycle after acceptance.
// Throughput: one input beat per cycle unless m_axis_tready holds the output; the
// output register lets a new beat in while the previous result is taken in the same cycle.
// Reset (synchronous, active low): sequencer idle, counters and latches zero,
// phase_ticks back to 10, output register empty.
module i2c_master_register_access (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // action[1:0], dev_addr[9:2], reg_addr[17:10], write_data[25:18],
    // read_length[33:26], sda_in[34], zero fill[39:35]
    input  logic [i2cm_pkg::IN_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], status[5:4],
    // read_valid[6], read_data[14:7], zero fill[15]
    output logic [i2cm_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import i2cm_pkg::*;

    logic [15:0] r_phase_ticks;
    t_state      r_state,  n_state;
    logic [15:0] r_pc,     n_pc;
    logic [3:0]  r_bc,     n_bc;
    logic [7:0]  r_shift,  n_shift;
    logic [7:0]  r_bytes,  n_bytes;
    logic [7:0]  r_dev,    n_dev;
    logic [7:0]  r_reg,    n_reg;
    logic [7:0]  r_pay,    n_pay;
    logic [1:0]  r_status, n_status;
    logic [1:0]  r_stage,  n_stage;
    logic        r_reading, n_reading;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic              r_out_last;

    logic [1:0] w_action;
    logic       w_sda;
    logic       w_start;
    logic       w_fire;
    logic       w_cfg_wr;
    logic [15:0] w_len;

    t_state      c_state;
    logic [7:0]  c_shift;
    logic [7:0]  c_bytes;
    logic [1:0]  c_status;
    logic [1:0]  c_stage;
    logic        c_reading;
    logic [3:0]  c_bc;
    logic [15:0] c_pc;

    logic [1:0] w_drv;
    logic       w_busy, w_done, w_rvalid, w_rlast;
    logic [7:0] w_rdata;

    assign w_action = s_axis_tdata[1:0];
    assign w_sda    = s_axis_tdata[34];
    assign w_fire   = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = ~r_out_valid | m_axis_tready;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & (paddr[2] == CFG_IDX_PHASE);
    assign prdata   = (paddr[2] == CFG_IDX_PHASE) ? {16'd0, r_phase_ticks} : 32'd0;
    assign w_len    = (r_phase_ticks == 16'd0) ? 16'd1 : r_phase_ticks;

    assign w_start = (r_state == S_IDLE) && ((w_action == ACT_WRITE) || (w_action == ACT_READ));

    // latch a new command ahead of the tick
    always_comb begin
        c_state   = r_state;
        c_shift   = r_shift;
        c_bytes   = r_bytes;
        c_status  = r_status;
        c_stage   = r_stage;
        c_reading = r_reading;
        c_bc      = r_bc;
        c_pc      = r_pc;
        n_dev     = r_dev;
        n_reg     = r_reg;
        n_pay     = r_pay;
        if (w_start) begin
            n_dev     = s_axis_tdata[9:2];
            n_reg     = s_axis_tdata[17:10];
            n_pay     = s_axis_tdata[25:18];
            c_bytes   = s_axis_tdata[33:26];
            c_reading = (w_action == ACT_READ);
            c_status  = STAT_OK;
            c_shift   = s_axis_tdata[9:2];
            c_stage   = STAGE_DEV;
            c_bc      = 4'd0;
            c_pc      = 16'd0;
            c_state   = S_STA;
        end
    end

    // next state
    always_comb begin
        n_state   = c_state;
        n_pc      = c_pc;
        n_bc      = c_bc;
        n_shift   = c_shift;
        n_bytes   = c_bytes;
        n_status  = c_status;
        n_stage   = c_stage;
        n_reading = c_reading;
        w_done    = 1'b0;
        w_rvalid  = 1'b0;
        w_rdata   = 8'd0;
        w_rlast   = 1'b0;
        if (c_state != S_IDLE) begin
            if (({1'b0, c_pc} + 17'd1) < {1'b0, w_len}) begin
                n_pc = c_pc + 16'd1;
            end else begin
                n_pc    = 16'd0;
                n_state = t_state'(c_state + 5'd1);
                case (c_state)
                    S_STC: begin
                        n_bc    = 4'd0;
                        n_state = S_TXS;
                    end
                    S_TXL: begin
                        n_shift = {c_shift[6:0], 1'b0};
                        n_bc    = c_bc + 4'd1;
                        n_state = (n_bc >= BITS_PER_BYTE) ? S_TAS : S_TXS;
                    end
                    S_TAH: begin
                        if (!c_reading && w_sda && (c_status == STAT_OK)) begin
                            n_status = c_stage + 2'd1;
                        end
                    end
                    S_TAL: begin
                        n_bc = 4'd0;
                        if (!c_reading) begin
                            if ((c_status != STAT_OK) || (c_stage >= STAGE_DATA)) begin
                                n_state = S_SPA;
                            end else begin
                                n_stage = c_stage + 2'd1;
                                n_shift = (n_stage == STAGE_REG) ? r_reg : r_pay;
                                n_state = S_TXS;
                            end
                        end else if (c_stage == STAGE_DEV) begin
                            n_stage = STAGE_REG;
                            n_shift = r_reg;
                            n_state = S_TXS;
                        end else if (c_stage == STAGE_REG) begin
                            n_stage = STAGE_DATA;
                            n_shift = n_dev | RD_BIT;
                            n_state = S_STA;
                        end else begin
                            n_shift = 8'd0;
                            n_state = (c_bytes == 8'd0) ? S_SPA : S_RXH;
                        end
                    end
                    S_RXH: begin
                        n_shift = {c_shift[6:0], w_sda};
                        n_bc    = c_bc + 4'd1;
                        if (n_bc >= BITS_PER_BYTE) begin
                            w_rvalid = 1'b1;
                            w_rdata  = n_shift;
                            w_rlast  = (c_bytes == 8'd1);
                            n_bytes  = c_bytes - 8'd1;
                        end
                    end
                    S_RXL: begin
                        n_state = (c_bc >= BITS_PER_BYTE) ? S_RAS : S_RXH;
                    end
                    S_RAL: begin
                        n_bc    = 4'd0;
                        n_shift = 8'd0;
                        n_state = (c_bytes == 8'd0) ? S_SPA : S_RXH;
                    end
                    S_SPC: begin
                        w_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // line drives, scl in bit 1, sda in bit 0
    always_comb begin
        w_busy = (c_state != S_IDLE);
        case (c_state)
            S_STA:        w_drv = 2'b11;
            S_STB:        w_drv = 2'b10;
            S_STC:        w_drv = 2'b00;
            S_TXS, S_TXL: w_drv = {1'b0, c_shift[7]};
            S_TXH:        w_drv = {1'b1, c_shift[7]};
            S_TAS, S_TAL, S_RXL: w_drv = 2'b01;
            S_TAH, S_RXH: w_drv = 2'b11;
            S_RAS, S_RAL: w_drv = {1'b0, c_bytes == 8'd0};
            S_RAH:        w_drv = {1'b1, c_bytes == 8'd0};
            S_SPA:        w_drv = 2'b00;
            S_SPB:        w_drv = 2'b10;
            default:      w_drv = 2'b11;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (w_cfg_wr) begin
            r_phase_ticks <= pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= 16'd0;
            r_bc      <= 4'd0;
            r_shift   <= 8'd0;
            r_bytes   <= 8'd0;
            r_dev     <= 8'd0;
            r_reg     <= 8'd0;
            r_pay     <= 8'd0;
            r_status  <= STAT_OK;
            r_stage   <= STAGE_DEV;
            r_reading <= 1'b0;
        end else if (w_fire) begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_bc      <= n_bc;
            r_shift   <= n_shift;
            r_bytes   <= n_bytes;
            r_dev     <= n_dev;
            r_reg     <= n_reg;
            r_pay     <= n_pay;
            r_status  <= n_status;
            r_stage   <= n_stage;
            r_reading <= n_reading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {1'b0, w_rdata, w_rvalid, n_status, w_done, w_busy,
                           w_drv[0], w_drv[1]};
            r_out_last <= w_rlast;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== tb/tb_i2c_master_register_access.sv =====
// Self-checking testbench for the I2C master register access block.
`timescale 1ns / 100ps

module tb_i2c_master_register_access;
    import i2cm_pkg::*;

    localparam logic [1:0] ACT_NONE   = 2'd3;
    localparam logic [2:0] PHASE_ADDR = 3'(CFG_IDX_PHASE) * 3'd4;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_length;
        logic       sda_in;
    } t_tick;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [1:0] status;
        logic       rvalid;
        logic [7:0] rdata;
        logic       rlast;
    } t_line_beat;

    class line_scoreboard;
        logic [15:0] phase_ticks = PHASE_TICKS_RESET;
        t_state      st = S_IDLE;
        int          phase_cnt = 0;
        logic [3:0]  bit_cnt = '0;
        logic [7:0]  shifter = '0;
        logic [7:0]  bytes_left = '0;
        logic [7:0]  dev_q = '0;
        logic [7:0]  reg_q = '0;
        logic [7:0]  data_q = '0;
        logic [1:0]  status_q = STAT_OK;
        logic [1:0]  stage = STAGE_DEV;
        logic        reading = 1'b0;
        t_line_beat  line_q[$];
        int          errors = 0;

        function int pending();
            return line_q.size();
        endfunction

        // {scl, sda} for the current state
        function logic [1:0] line_drive();
            case (st)
                S_STA: return 2'b11;
                S_STB, S_SPB: return 2'b10;
                S_STC, S_SPA: return 2'b00;
                S_TXS, S_TXL: return {1'b0, shifter[7]};
                S_TXH: return {1'b1, shifter[7]};
                S_TAS, S_TAL, S_RXL: return 2'b01;
                S_TAH, S_RXH: return 2'b11;
                S_RAS, S_RAL: return {1'b0, bytes_left == 8'd0};
                S_RAH: return {1'b1, bytes_left == 8'd0};
                default: return 2'b11;
            endcase
        endfunction

        function void note_tick(t_tick t);
            t_line_beat b;
            t_state     nx;
            int         len;
            len = (phase_ticks == 16'd0) ? 1 : int'(phase_ticks);
            if (st == S_IDLE && (t.action == ACT_WRITE || t.action == ACT_READ)) begin
                dev_q      = t.dev_addr;
                reg_q      = t.reg_addr;
                data_q     = t.write_data;
                bytes_left = t.read_length;
                reading    = (t.action == ACT_READ);
                status_q   = STAT_OK;
                shifter    = t.dev_addr;
                stage      = STAGE_DEV;
                bit_cnt    = '0;
                phase_cnt  = 0;
                st         = S_STA;
            end
            b = '0;
            {b.scl, b.sda} = line_drive();
            if (st != S_IDLE) begin
                b.busy = 1'b1;
                if (phase_cnt + 1 < len) begin
                    phase_cnt++;
                end else begin
                    nx = t_state'(st + 5'd1);
                    phase_cnt = 0;
                    case (st)
                        S_STC: begin
                            bit_cnt = '0;
                            nx = S_TXS;
                        end
                        S_TXL: begin
                            shifter = shifter << 1;
                            bit_cnt = bit_cnt + 4'd1;
                            nx = (bit_cnt >= BITS_PER_BYTE) ? S_TAS : S_TXS;
                        end
                        S_TAH: begin
                            if (!reading && t.sda_in && status_q == STAT_OK)
                                status_q = stage + 2'd1;
                        end
                        S_TAL: begin
                            bit_cnt = '0;
                            if (!reading) begin
                                if (status_q != STAT_OK || stage >= STAGE_DATA) begin
                                    nx = S_SPA;
                                end else begin
                                    stage = stage + 2'd1;
                                    shifter = (stage == STAGE_REG) ? reg_q : data_q;
                                    nx = S_TXS;
                                end
                            end else if (stage == STAGE_DEV) begin
                                stage = STAGE_REG;
                                shifter = reg_q;
                                nx = S_TXS;
                            end else if (stage == STAGE_REG) begin
                                stage = STAGE_DATA;
                                shifter = dev_q | RD_BIT;
                                nx = S_STA;
                            end else begin
                                shifter = '0;
                                nx = (bytes_left == 8'd0) ? S_SPA : S_RXH;
                            end
                        end
                        S_RXH: begin
                            shifter = {shifter[6:0], t.sda_in};
                            bit_cnt = bit_cnt + 4'd1;
                            if (bit_cnt >= BITS_PER_BYTE) begin
                                b.rvalid = 1'b1;
                                b.rdata = shifter;
                                b.rlast = (bytes_left == 8'd1);
                                bytes_left = bytes_left - 8'd1;
                            end
                        end
                        S_RXL: nx = (bit_cnt >= BITS_PER_BYTE) ? S_RAS : S_RXH;
                        S_RAL: begin
                            bit_cnt = '0;
                            shifter = '0;
                            nx = (bytes_left == 8'd0) ? S_SPA : S_RXH;
                        end
                        S_SPC: begin
                            b.done = 1'b1;
                            nx = S_IDLE;
                        end
                        default: ;
                    endcase
                    st = nx;
                end
            end
            b.status = status_q;
            line_q.push_back(b);
        endfunction

        function void cmp(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(logic [OUT_W-1:0] d, logic last);
            t_line_beat e;
            if (line_q.size() == 0) begin
                $error("output beat %h with nothing expected", d);
                errors++;
                return;
            end
            e = line_q.pop_front();
            cmp("scl_out", 8'(e.scl), 8'(d[0]));
            cmp("sda_out", 8'(e.sda), 8'(d[1]));
            cmp("busy_res", 8'(e.busy), 8'(d[2]));
            cmp("done_res", 8'(e.done), 8'(d[3]));
            cmp("status", 8'(e.status), 8'(d[5:4]));
            cmp("read_valid", 8'(e.rvalid), 8'(d[6]));
            cmp("read_data", e.rdata, d[14:7]);
            cmp("read_last", 8'(e.rlast), 8'(last));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tlast;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    line_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int ticks_sent = 0;

    i2c_master_register_access u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic t_tick rand_tick();
        t_tick t;
        t.action      = 2'($urandom);
        t.dev_addr    = 8'($urandom);
        t.reg_addr    = 8'($urandom);
        t.write_data  = 8'($urandom);
        t.read_length = 8'($urandom);
        t.sda_in      = 1'($urandom);
        return t;
    endfunction

    // mostly plain ticks, some stray commands the busy sequencer must ignore
    function automatic t_tick bus_tick(logic [2:0] nack_mask);
        t_tick t;
        t = rand_tick();
        t.action = ($urandom_range(9) == 0) ? 2'($urandom_range(1, 3)) : ACT_TICK;
        if (sb.st == S_TAH && !sb.reading)
            t.sda_in = nack_mask[sb.stage];
        return t;
    endfunction

    task automatic send_tick(t_tick t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, t.sda_in, t.read_length, t.write_data, t.reg_addr,
                          t.dev_addr, t.action};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(t);
        ticks_sent++;
    endtask

    task automatic run_transfer(logic [1:0] act, logic [7:0] dev, logic [7:0] rg,
                                logic [7:0] wd, logic [7:0] len, logic [2:0] nack_mask);
        t_tick t;
        t = rand_tick();
        t.action      = act;
        t.dev_addr    = dev;
        t.reg_addr    = rg;
        t.write_data  = wd;
        t.read_length = len;
        send_tick(t);
        while (sb.st != S_IDLE)
            send_tick(bus_tick(nack_mask));
    endtask

    task automatic idle_ticks(int n);
        t_tick t;
        for (int i = 0; i < n; i++) begin
            t = rand_tick();
            t.action = $urandom_range(1) ? ACT_TICK : ACT_NONE;
            send_tick(t);
        end
    endtask

    task automatic apb_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PHASE_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_phase(logic [15:0] v);
        logic [31:0] rd;
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        apb_access(1'b1, {16'($urandom), v}, rd);
        apb_access(1'b0, $urandom, rd);
        if (rd[15:0] !== v) begin
            $error("phase_ticks: expected %0h, got %0h", v, rd[15:0]);
            sb.errors++;
        end
        sb.phase_ticks = v;
    endtask

    initial begin
        int          goal;
        int          pick;
        logic [7:0]  len;
        logic [2:0]  mask;
        logic [31:0] rd;
        sb = new;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 31;
        recv_idle_pct = 88;
        apb_access(1'b0, 32'd0, rd);
        if (rd[15:0] !== PHASE_TICKS_RESET) begin
            $error("phase_ticks: expected %0h, got %0h", PHASE_TICKS_RESET, rd[15:0]);
            sb.errors++;
        end

        write_phase(16'd1);
        run_transfer(ACT_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'b000);
        run_transfer(ACT_WRITE, 8'h3C, 8'h11, 8'h22, 8'h01, 3'b001);
        run_transfer(ACT_WRITE, 8'h3C, 8'h11, 8'h22, 8'h01, 3'b010);
        run_transfer(ACT_WRITE, 8'h3C, 8'h11, 8'h22, 8'h01, 3'b100);
        idle_ticks(4);
        run_transfer(ACT_READ, 8'hA0, 8'h07, 8'h00, 8'd0, 3'b111);
        run_transfer(ACT_READ, 8'hA1, 8'hF0, 8'hFF, 8'd1, 3'b000);
        write_phase(16'd0);
        run_transfer(ACT_WRITE, 8'h52, 8'h34, 8'h96, 8'd3, 3'b000);
        write_phase(16'hFFFF);
        idle_ticks(20);
        write_phase(16'd2);

        for (int m = 0; m < 3; m++) begin
            send_idle_pct = (m == 0) ? 31 : (m == 1) ? 88 : 0;
            recv_idle_pct = (m == 0) ? 88 : (m == 1) ? 31 : 0;
            goal = ticks_sent + 155;
            while (ticks_sent < goal) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    write_phase(($urandom_range(3) == 0) ? 16'($urandom_range(2, 3))
                                                         : 16'($urandom_range(1)));
                end else if (pick < 18) begin
                    idle_ticks($urandom_range(1, 4));
                end else begin
                    pick = $urandom_range(99);
                    len = (pick < 70) ? 8'($urandom_range(3)) :
                          (pick < 95) ? 8'($urandom_range(4, 16)) : 8'($urandom_range(17, 40));
                    mask = $urandom_range(1) ? 3'b000 :
                           ($urandom_range(3) == 0) ? 3'($urandom) : 3'(1 << $urandom_range(2));
                    run_transfer($urandom_range(1) ? ACT_WRITE : ACT_READ, 8'($urandom),
                                 8'($urandom), 8'($urandom), len, mask);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_i2c_master_register_access: clean");
        else
            $display("tb_i2c_master_register_access: errors");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb_i2c_master_register_access: errors");
        $finish;
    end

endmodule
